// File: rtl/ksdv_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// kick and snare drum voice. No dependencies.
`timescale 1ns / 1ps

package ksdv_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_SNARE_LENGTH    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KICK_LENGTH     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KICK_START_STEP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KICK_END_STEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SNARE_LEVEL     = 3'd4;

    localparam logic [15:0] RST_SNARE_LENGTH    = 16'd8820;
    localparam logic [15:0] RST_KICK_LENGTH     = 16'd8820;
    localparam logic [14:0] RST_KICK_START_STEP = 15'd223;
    localparam logic [14:0] RST_KICK_END_STEP   = 15'd30;
    localparam logic [14:0] RST_SNARE_LEVEL     = 15'd13107;

    localparam logic [7:0] BYTE_KICK  = 8'h6B;
    localparam logic [7:0] BYTE_SNARE = 8'h73;

    localparam logic [31:0] LFSR_MASK = 32'hA300_0000;
    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

    localparam logic [16:0] ENV_FULL = 17'h1_0000;

    // multiplier operand select
    localparam logic [1:0] MUL_NOISE = 2'd0;
    localparam logic [1:0] MUL_DIFF  = 2'd1;
    localparam logic [1:0] MUL_SNARE = 2'd2;
    localparam logic [1:0] MUL_KICK  = 2'd3;

    // divider operand select
    localparam logic [1:0] DIV_ENV_S = 2'd0;
    localparam logic [1:0] DIV_STEP  = 2'd1;
    localparam logic [1:0] DIV_ENV_K = 2'd2;

    typedef struct packed {
        logic       load_byte;
        logic       tick_start;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       div_start;
        logic [1:0] div_sel;
        logic       cap_scaled;
        logic       cap_kprod;
        logic       cap_env_s;
        logic       cap_snare;
        logic       cap_step;
        logic       cap_addr;
        logic       cap_rom;
        logic       cap_env_k;
        logic       out_load;
    } ksdv_cmd_t;

    typedef struct packed {
        logic div_busy;
    } ksdv_stat_t;

endpackage

// File: rtl/ksdv_div.sv
// Radix-4 restoring divider, two quotient bits per cycle, 16-bit quotient.
// Numerator high half must be below the divisor. Uses nothing outside.
`timescale 1ns / 1ps

module ksdv_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [15:0] den,
    output logic        busy,
    output logic [15:0] quot
);

    localparam int DIV_CYCLES = 8;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      low_reg;
    logic [15:0]      den_reg;
    logic [15:0]      quot_reg;

    logic [16:0] r1, r2;
    logic        ge1, ge2;
    logic [15:0] rem1, rem2;

    always_comb begin
        r1   = {rem_reg, low_reg[15]};
        ge1  = r1 >= {1'b0, den_reg};
        rem1 = ge1 ? 16'(r1 - {1'b0, den_reg}) : r1[15:0];
        r2   = {rem1, low_reg[14]};
        ge2  = r2 >= {1'b0, den_reg};
        rem2 = ge2 ? 16'(r2 - {1'b0, den_reg}) : r2[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_CYCLES - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[31:16];
            low_reg <= num[15:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg  <= rem2;
            low_reg  <= {low_reg[13:0], 2'b00};
            quot_reg <= {quot_reg[13:0], ge1, ge2};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/ksdv_dp.sv
// Datapath: config registers, voice state, LFSR, shared multiplier, divider,
// sine ROM and output register. Depends on ksdv_pkg and ksdv_div.
`timescale 1ns / 1ps

module ksdv_dp
    import ksdv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ksdv_cmd_t             cmd,
    output ksdv_stat_t            stat,
    input  logic                  cfg_wr,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            s_rx_byte,
    output logic signed [15:0]    m_sample,
    output logic                  m_snare_busy,
    output logic                  m_kick_busy
);

    localparam int FRAC_BITS = PHASE_BITS - 2;
    localparam int DW        = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW        = FRAC_BITS + DW;
    localparam int SUM_W     = ((PHASE_BITS > 15) ? PHASE_BITS : 15) + 1;

    typedef logic [14:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    function automatic logic [14:0] sine_entry(input int i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // configuration
    logic [15:0] snare_len_reg;
    logic [15:0] kick_len_reg;
    logic [14:0] kick_start_reg;
    logic [14:0] kick_end_reg;
    logic [14:0] snare_level_reg;

    // voice state
    logic [15:0]           snare_left_reg;
    logic [15:0]           kick_left_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [31:0]           lfsr_reg;
    logic                  sbusy_reg;
    logic                  kbusy_reg;

    // working registers
    logic signed [35:0] p_reg;
    logic signed [15:0] scaled_reg;
    logic [30:0]        kprod_reg;
    logic [16:0]        env_s_reg;
    logic [16:0]        env_k_reg;
    logic signed [16:0] snare_reg;
    logic [DW-1:0]      addr_reg;
    logic [1:0]         quad_reg;
    logic [14:0]        rom_reg;

    logic signed [15:0] sample_reg;
    logic               sbusy_out_reg;
    logic               kbusy_out_reg;

    logic               snare_full;
    logic               kick_full;
    logic signed [15:0] step_diff;
    logic               diff_neg;
    logic [14:0]        diff_abs;
    logic [31:0]        lfsr_next;
    logic signed [15:0] sine_val;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic [31:0]        div_num;
    logic [15:0]        div_den;
    logic               div_busy;
    logic [15:0]        div_quot;
    logic signed [15:0] step_off;
    logic [15:0]        step_val;
    logic [14:0]        step_sel;
    logic [SUM_W-1:0]   phase_sum;
    logic [PW-1:0]      frac_scaled;
    logic [DW-1:0]      idx;
    logic [DW-1:0]      idx_mirror;
    logic signed [16:0] kick_val;
    logic signed [17:0] mix;
    logic signed [15:0] mix_sat;

    assign snare_full = snare_left_reg >= snare_len_reg;
    assign kick_full  = kick_left_reg >= kick_len_reg;
    assign step_diff  = signed'({1'b0, kick_start_reg}) - signed'({1'b0, kick_end_reg});
    assign diff_neg   = step_diff[15];
    assign diff_abs   = diff_neg ? 15'(-step_diff) : step_diff[14:0];
    assign lfsr_next  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
    assign sine_val   = quad_reg[1] ? -signed'({1'b0, rom_reg}) : signed'({1'b0, rom_reg});

    always_comb begin
        case (cmd.mul_sel)
            MUL_NOISE: begin
                mul_a = {{2{lfsr_reg[15]}}, lfsr_reg[15:0]};
                mul_b = {3'b000, snare_level_reg};
            end
            MUL_DIFF: begin
                mul_a = {3'b000, diff_abs};
                mul_b = {2'b00, kick_left_reg};
            end
            MUL_SNARE: begin
                mul_a = {{2{scaled_reg[15]}}, scaled_reg};
                mul_b = {1'b0, env_s_reg};
            end
            default: begin
                mul_a = {{2{sine_val[15]}}, sine_val};
                mul_b = {1'b0, env_k_reg};
            end
        endcase
    end

    always_comb begin
        case (cmd.div_sel)
            DIV_STEP: begin
                div_num = {1'b0, kprod_reg};
                div_den = kick_len_reg;
            end
            DIV_ENV_K: begin
                div_num = {kick_left_reg, 16'h0000};
                div_den = kick_len_reg;
            end
            default: begin
                div_num = {snare_left_reg, 16'h0000};
                div_den = snare_len_reg;
            end
        endcase
    end

    ksdv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    assign stat.div_busy = div_busy;

    always_comb begin
        step_off    = diff_neg ? -signed'({1'b0, div_quot[14:0]})
                               : signed'({1'b0, div_quot[14:0]});
        step_val    = 16'({1'b0, kick_end_reg} + step_off);
        step_sel    = kick_full ? kick_start_reg : step_val[14:0];
        phase_sum   = SUM_W'(phase_reg) + SUM_W'(step_sel);
        frac_scaled = PW'(phase_reg[FRAC_BITS-1:0]) * PW'(SINE_TABLE_DEPTH);
        idx         = frac_scaled[PW-1:FRAC_BITS];
        idx_mirror  = DW'(SINE_TABLE_DEPTH) - idx;
        kick_val    = kbusy_reg ? p_reg[32:16] : 17'sd0;
        mix         = {snare_reg[16], snare_reg} + {kick_val[16], kick_val};
        if (mix > 18'sd32767) begin
            mix_sat = 16'sh7FFF;
        end else if (mix < -18'sd32768) begin
            mix_sat = -16'sh8000;
        end else begin
            mix_sat = mix[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snare_len_reg   <= RST_SNARE_LENGTH;
            kick_len_reg    <= RST_KICK_LENGTH;
            kick_start_reg  <= RST_KICK_START_STEP;
            kick_end_reg    <= RST_KICK_END_STEP;
            snare_level_reg <= RST_SNARE_LEVEL;
        end else if (cfg_wr) begin
            unique case (cfg_addr)
                CFG_SNARE_LENGTH:    snare_len_reg   <= cfg_data;
                CFG_KICK_LENGTH:     kick_len_reg    <= cfg_data;
                CFG_KICK_START_STEP: kick_start_reg  <= cfg_data[14:0];
                CFG_KICK_END_STEP:   kick_end_reg    <= cfg_data[14:0];
                CFG_SNARE_LEVEL:     snare_level_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snare_left_reg <= '0;
            kick_left_reg  <= '0;
            phase_reg      <= '0;
            lfsr_reg       <= LFSR_SEED;
            sbusy_reg      <= 1'b0;
            kbusy_reg      <= 1'b0;
        end else begin
            if (cmd.load_byte) begin
                if (s_rx_byte == BYTE_KICK) begin
                    kick_left_reg <= kick_len_reg;
                end else if (s_rx_byte == BYTE_SNARE) begin
                    snare_left_reg <= snare_len_reg;
                end
            end
            if (cmd.tick_start) begin
                sbusy_reg <= snare_left_reg != 16'd0;
                kbusy_reg <= kick_left_reg != 16'd0;
                if (snare_left_reg != 16'd0) begin
                    lfsr_reg <= lfsr_next;
                end
            end
            if (cmd.cap_step && kbusy_reg) begin
                phase_reg <= phase_sum[PHASE_BITS-1:0];
            end
            if (cmd.out_load) begin
                if (sbusy_reg) begin
                    snare_left_reg <= snare_left_reg - 16'd1;
                end
                if (kbusy_reg) begin
                    kick_left_reg <= kick_left_reg - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            p_reg <= mul_a * mul_b;
        end
        if (cmd.cap_scaled) begin
            scaled_reg <= p_reg[30:15];
        end
        if (cmd.cap_kprod) begin
            kprod_reg <= p_reg[30:0];
        end
        if (cmd.cap_env_s) begin
            env_s_reg <= snare_full ? ENV_FULL : {1'b0, div_quot};
        end
        if (cmd.cap_snare) begin
            snare_reg <= sbusy_reg ? p_reg[32:16] : 17'sd0;
        end
        if (cmd.cap_addr) begin
            addr_reg <= phase_reg[FRAC_BITS] ? idx_mirror : idx;
            quad_reg <= phase_reg[PHASE_BITS-1:PHASE_BITS-2];
        end
        if (cmd.cap_rom) begin
            rom_reg <= SINE_ROM[addr_reg];
        end
        if (cmd.cap_env_k) begin
            env_k_reg <= kick_full ? ENV_FULL : {1'b0, div_quot};
        end
        if (cmd.out_load) begin
            sample_reg    <= mix_sat;
            sbusy_out_reg <= sbusy_reg;
            kbusy_out_reg <= kbusy_reg;
        end
    end

    assign m_sample     = sample_reg;
    assign m_snare_busy = sbusy_out_reg;
    assign m_kick_busy  = kbusy_out_reg;

endmodule

// File: rtl/ksdv_ctrl.sv
// Controller: sequences one tick through multiplier, divider and ROM, and
// owns the input and result handshakes. Depends on ksdv_pkg.
`timescale 1ns / 1ps

module ksdv_ctrl
    import ksdv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_cmd,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  ksdv_stat_t stat,
    output ksdv_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL_NOISE = 4'd1;
    localparam logic [3:0] ST_MUL_DIFF  = 4'd2;
    localparam logic [3:0] ST_WAIT_DS   = 4'd3;
    localparam logic [3:0] ST_MUL_SNARE = 4'd4;
    localparam logic [3:0] ST_WAIT_STEP = 4'd5;
    localparam logic [3:0] ST_ADDR      = 4'd6;
    localparam logic [3:0] ST_ROM       = 4'd7;
    localparam logic [3:0] ST_WAIT_DK   = 4'd8;
    localparam logic [3:0] ST_MUL_KICK  = 4'd9;
    localparam logic [3:0] ST_SUM       = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd) begin
                        cmd.load_byte = 1'b1;
                    end else begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_MUL_NOISE;
                    end
                end
            end
            ST_MUL_NOISE: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_NOISE;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ENV_S;
                state_next    = ST_MUL_DIFF;
            end
            ST_MUL_DIFF: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_DIFF;
                cmd.cap_scaled = 1'b1;
                state_next     = ST_WAIT_DS;
            end
            ST_WAIT_DS: begin
                cmd.cap_kprod = 1'b1;
                if (!stat.div_busy) begin
                    cmd.cap_env_s = 1'b1;
                    state_next    = ST_MUL_SNARE;
                end
            end
            ST_MUL_SNARE: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_SNARE;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_STEP;
                state_next    = ST_WAIT_STEP;
            end
            ST_WAIT_STEP: begin
                cmd.cap_snare = 1'b1;
                cmd.div_sel   = DIV_STEP;
                if (!stat.div_busy) begin
                    cmd.cap_step = 1'b1;
                    state_next   = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cmd.cap_addr  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ENV_K;
                state_next    = ST_ROM;
            end
            ST_ROM: begin
                cmd.cap_rom = 1'b1;
                state_next  = ST_WAIT_DK;
            end
            ST_WAIT_DK: begin
                if (!stat.div_busy) begin
                    cmd.cap_env_k = 1'b1;
                    state_next    = ST_MUL_KICK;
                end
            end
            ST_MUL_KICK: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KICK;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_cmd) |=> (state_reg == ST_MUL_NOISE))
        else $error("tick transfer did not start the sequence");

    a_byte_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd) |=> (state_reg == ST_IDLE && !stat.div_busy))
        else $error("byte transfer left idle");
`endif

endmodule

// File: rtl/kick_snare_drum_voice_core.sv
// Top level of the kick and snare drum voice: controller plus datapath.
// Depends on ksdv_pkg, ksdv_ctrl, ksdv_dp (and ksdv_div below it).
//
//   channel  direction  handshake             payload
//   s_       in         s_valid / s_ready     s_cmd, s_rx_byte
//   m_       out        m_valid / m_ready     m_sample, m_snare_busy, m_kick_busy
//   cfg_     in         cfg_valid / cfg_ready cfg_addr, cfg_data
//
// A byte transfer leaves the controller idle. A tick runs three divisions
// (two envelopes and the sweep step) on the shared radix-4 divider before its
// result. One item is in work at a time; s_ready is high when idle, so the
// next item is taken the cycle after a tick's result is loaded.
// The result register lets the next item in while a result waits; a tick only
// stalls at its last step when the earlier result is still not taken.
// Reset is synchronous, active low; cfg_ready is always high.
`timescale 1ns / 1ps

module kick_snare_drum_voice_core
    import ksdv_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [7:0]            s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_sample,
    output logic                  m_snare_busy,
    output logic                  m_kick_busy,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ksdv_cmd_t  cmd;
    ksdv_stat_t stat;

    assign cfg_ready = 1'b1;

    ksdv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ksdv_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_rx_byte    (s_rx_byte),
        .m_sample     (m_sample),
        .m_snare_busy (m_snare_busy),
        .m_kick_busy  (m_kick_busy)
    );

endmodule
